[design/jedec_fuse_map_parser_macros.svh]
// ----------------------------------------------------------------------------
// JEDEC fuse map parser assertion macros
// Shared assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef JEDEC_FUSE_MAP_PARSER_MACROS_SVH
`define JEDEC_FUSE_MAP_PARSER_MACROS_SVH

// Check a condition at every edge outside reset
`define JFMP_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Check that a trigger is followed by a consequence at the next edge
`define JFMP_ASSERT_NEXT(label, trig, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (conseq)) \
      else $error(msg);

// Check a consequence at the edge after reset is seen
`define JFMP_ASSERT_AFTER_RESET(label, conseq, msg) \
   label: assert property (@(posedge clock) reset |=> (conseq)) \
      else $error(msg);

`endif

[design/jfmp_pkg.sv]
// ----------------------------------------------------------------------------
// JEDEC fuse map parser package
// Shared defaults, character classes, the token passed from the front end
// to the back end, the result beat and the parse states.
// ----------------------------------------------------------------------------
package jfmp_pkg;

   // Parameter defaults
   localparam int FUSE_CAPACITY_DEF   = 16384;
   localparam int MAX_TEXT_LENGTH_DEF = 65536;

   // Character class of one byte
   typedef enum logic [2:0] {
      KIND_OTHER,
      KIND_STAR,
      KIND_L,
      KIND_F,
      KIND_G,
      KIND_Q,
      KIND_C,
      KIND_P
   } char_kind_type;

   // Classified character, front end to back end
   typedef struct packed {
      char_kind_type kind;
      logic          is_ws;
      logic          is_dig;
      logic          is_hex;
      logic [3:0]    nib;
      logic          last;
   } token_type;

   // One result beat
   typedef struct packed {
      logic        write_valid;
      logic        fill_valid;
      logic        bit_value;
      logic [13:0] fuse_address;
      logic        parse_error;
      logic [15:0] error_position;
      logic        done_res;
      logic [7:0]  pin_count;
      logic [15:0] fuse_total;
      logic        security_bit;
      logic [15:0] checksum_given;
   } result_type;

   // Field parser states
   typedef enum logic [3:0] {
      ST_OUTSIDE,
      ST_SKIP,
      ST_CMD,
      ST_L_FIRST,
      ST_L_ADDR,
      ST_F_BIT,
      ST_L_BITS,
      ST_Q_SEL,
      ST_QP_FIRST,
      ST_QF_FIRST,
      ST_QP_DIGS,
      ST_QF_DIGS,
      ST_Q_TAIL,
      ST_G_BIT,
      ST_C_FIRST,
      ST_C_DIGS
   } parse_state_type;

endpackage

[design/jfmp_fifo2.sv]
// ----------------------------------------------------------------------------
// JEDEC fuse map parser two-entry queue
// Head and tail slots with a fill count; full and empty come from the count
// register only, so neither side sees a path from the other.
// ----------------------------------------------------------------------------
module jfmp_fifo2 #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic [WIDTH-1:0] head_ff;
   logic [WIDTH-1:0] tail_ff;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = head_ff;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Track occupancy
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Move beats through the slots
   always_ff @(posedge clock) begin
      if (do_pop) begin
         if (count_ff == 2'd2) begin
            head_ff <= tail_ff;
         end else if (do_push) begin
            head_ff <= push_data;
         end
      end else if (do_push) begin
         if (count_ff == 2'd0) begin
            head_ff <= push_data;
         end else begin
            tail_ff <= push_data;
         end
      end
   end

endmodule

[design/jfmp_front.sv]
// ----------------------------------------------------------------------------
// JEDEC fuse map parser front end
// Accepts characters, classifies each one and queues the token for the
// parse back end.
// ----------------------------------------------------------------------------
module jfmp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_character,
   input  logic                req_last_char,
   input  logic                req_push,
   output logic                req_full,
   input  logic                tok_pop,
   output jfmp_pkg::token_type tok,
   output logic                tok_empty
);

   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [7:0] CHAR_L    = 8'h4C;
   localparam logic [7:0] CHAR_F    = 8'h46;
   localparam logic [7:0] CHAR_G    = 8'h47;
   localparam logic [7:0] CHAR_Q    = 8'h51;
   localparam logic [7:0] CHAR_C    = 8'h43;
   localparam logic [7:0] CHAR_P    = 8'h50;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam int         TOK_W     = $bits(jfmp_pkg::token_type);

   jfmp_pkg::token_type  cls;
   logic [TOK_W-1:0]     tok_bits;
   logic [7:0]           hex_off;

   // Classify the incoming byte
   always_comb begin
      cls.last   = req_last_char;
      cls.is_ws  = (req_character == 8'h20) || (req_character inside {[8'h09:8'h0D]});
      cls.is_dig = req_character inside {[8'h30:8'h39]};
      cls.is_hex = cls.is_dig || (req_character inside {[8'h41:8'h46], [8'h61:8'h66]});
      if (cls.is_dig) begin
         hex_off = req_character - CHAR_ZERO;
      end else if (req_character inside {[8'h41:8'h46]}) begin
         hex_off = req_character - 8'd55;
      end else begin
         hex_off = req_character - 8'd87;
      end
      cls.nib = hex_off[3:0];
      case (req_character)
         CHAR_STAR: cls.kind = jfmp_pkg::KIND_STAR;
         CHAR_L:    cls.kind = jfmp_pkg::KIND_L;
         CHAR_F:    cls.kind = jfmp_pkg::KIND_F;
         CHAR_G:    cls.kind = jfmp_pkg::KIND_G;
         CHAR_Q:    cls.kind = jfmp_pkg::KIND_Q;
         CHAR_C:    cls.kind = jfmp_pkg::KIND_C;
         CHAR_P:    cls.kind = jfmp_pkg::KIND_P;
         default:   cls.kind = jfmp_pkg::KIND_OTHER;
      endcase
   end

   // Queue tokens toward the back end
   jfmp_fifo2 #(
      .WIDTH(TOK_W)
   ) u_tok_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_data(TOK_W'(cls)),
      .full     (req_full),
      .pop      (tok_pop),
      .pop_data (tok_bits),
      .empty    (tok_empty)
   );

   assign tok = jfmp_pkg::token_type'(tok_bits);

endmodule

[design/jfmp_back.sv]
// ----------------------------------------------------------------------------
// JEDEC fuse map parser back end
// Runs the field state machine, when not stalled, on one token per cycle,
// keeps running totals and error record and queues a result per character.
// ----------------------------------------------------------------------------
module jfmp_back #(
   parameter int FUSE_CAPACITY   = jfmp_pkg::FUSE_CAPACITY_DEF,
   parameter int MAX_TEXT_LENGTH = jfmp_pkg::MAX_TEXT_LENGTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  jfmp_pkg::token_type  tok,
   input  logic                 tok_empty,
   output logic                 tok_pop,
   output jfmp_pkg::result_type rsp,
   output logic                 rsp_empty,
   input  logic                 rsp_pop
);

   localparam int AW    = $clog2(FUSE_CAPACITY + 1);
   localparam int MW    = AW + 4;
   localparam int IW    = $clog2(MAX_TEXT_LENGTH + 1);
   localparam int RES_W = $bits(jfmp_pkg::result_type);

   localparam logic [AW-1:0] CAP_A   = AW'(FUSE_CAPACITY);
   localparam logic [MW-1:0] CAP_M   = MW'(FUSE_CAPACITY);
   localparam logic [IW-1:0] IDX_MAX = IW'(MAX_TEXT_LENGTH);

   jfmp_pkg::parse_state_type state_ff, state_in;
   logic [AW-1:0]             addr_ff, addr_in;
   logic [7:0]                pins_ff, pins_in;
   logic [15:0]               fuses_ff, fuses_in;
   logic                      sec_ff, sec_in;
   logic [15:0]               csum_ff, csum_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic                      err_ff, err_in;
   logic [IW-1:0]             erridx_ff, erridx_in;

   logic                      fire;
   logic                      oq_full;
   logic                      is_bit;
   logic [MW-1:0]             addr_mul;
   logic [11:0]               pins_mul;
   logic [19:0]               fuses_mul;
   logic [IW-1:0]             pos_src;
   logic [31:0]               pos_wide;
   logic [31:0]               addr_wide;
   logic                      wv, fv, bv;
   logic [AW-1:0]             fa_src;
   jfmp_pkg::result_type      res;
   logic [RES_W-1:0]          rsp_bits;

   assign fire    = !tok_empty && !oq_full;
   assign tok_pop = fire;
   assign is_bit  = tok.is_dig && (tok.nib[3:1] == 3'd0);

   // Decimal accumulate steps
   assign addr_mul  = (MW'(addr_ff) << 3) + (MW'(addr_ff) << 1) + MW'(tok.nib);
   assign pins_mul  = (12'(pins_ff) << 3) + (12'(pins_ff) << 1) + 12'(tok.nib);
   assign fuses_mul = (20'(fuses_ff) << 3) + (20'(fuses_ff) << 1) + 20'(tok.nib);

   // Parse one token
   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      pins_in   = pins_ff;
      fuses_in  = fuses_ff;
      sec_in    = sec_ff;
      csum_in   = csum_ff;
      err_in    = err_ff;
      erridx_in = erridx_ff;
      wv        = 1'b0;
      fv        = 1'b0;
      bv        = 1'b0;
      fa_src    = '0;

      // Flag text past the length limit
      if (!err_ff && (idx_ff == IDX_MAX)) begin
         err_in    = 1'b1;
         erridx_in = idx_ff;
      end

      if (!err_in) begin
         if (tok.kind == jfmp_pkg::KIND_STAR) begin
            state_in = jfmp_pkg::ST_CMD;
         end else begin
            case (state_ff)
               jfmp_pkg::ST_CMD: begin
                  if (!tok.is_ws) begin
                     case (tok.kind)
                        jfmp_pkg::KIND_L: begin
                           addr_in  = '0;
                           state_in = jfmp_pkg::ST_L_FIRST;
                        end
                        jfmp_pkg::KIND_F: state_in = jfmp_pkg::ST_F_BIT;
                        jfmp_pkg::KIND_G: state_in = jfmp_pkg::ST_G_BIT;
                        jfmp_pkg::KIND_Q: state_in = jfmp_pkg::ST_Q_SEL;
                        jfmp_pkg::KIND_C: state_in = jfmp_pkg::ST_C_FIRST;
                        default:          state_in = jfmp_pkg::ST_SKIP;
                     endcase
                  end
               end
               jfmp_pkg::ST_L_FIRST: begin
                  if (tok.is_dig) begin
                     addr_in  = AW'(tok.nib);
                     state_in = jfmp_pkg::ST_L_ADDR;
                  end else begin
                     err_in    = 1'b1;
                     erridx_in = idx_ff;
                  end
               end
               jfmp_pkg::ST_L_ADDR: begin
                  if (tok.is_ws) begin
                     state_in = jfmp_pkg::ST_L_BITS;
                  end else if (tok.is_dig) begin
                     addr_in = (addr_mul >= CAP_M) ? CAP_A : addr_mul[AW-1:0];
                  end else begin
                     err_in    = 1'b1;
                     erridx_in = idx_ff;
                  end
               end
               jfmp_pkg::ST_F_BIT: begin
                  if (!tok.is_ws) begin
                     if (is_bit) begin
                        fv       = 1'b1;
                        bv       = tok.nib[0];
                        state_in = jfmp_pkg::ST_SKIP;
                     end else begin
                        err_in    = 1'b1;
                        erridx_in = idx_ff;
                     end
                  end
               end
               jfmp_pkg::ST_L_BITS: begin
                  if (!tok.is_ws) begin
                     if (is_bit && (addr_ff < CAP_A)) begin
                        wv      = 1'b1;
                        bv      = tok.nib[0];
                        fa_src  = addr_ff;
                        addr_in = addr_ff + AW'(1);
                     end else begin
                        err_in    = 1'b1;
                        erridx_in = idx_ff;
                     end
                  end
               end
               jfmp_pkg::ST_Q_SEL: begin
                  if (!tok.is_ws) begin
                     if (tok.kind == jfmp_pkg::KIND_P) begin
                        pins_in  = '0;
                        state_in = jfmp_pkg::ST_QP_FIRST;
                     end else if (tok.kind == jfmp_pkg::KIND_F) begin
                        fuses_in = '0;
                        state_in = jfmp_pkg::ST_QF_FIRST;
                     end else begin
                        state_in = jfmp_pkg::ST_CMD;
                     end
                  end
               end
               jfmp_pkg::ST_QP_FIRST: begin
                  if (!tok.is_ws) begin
                     if (tok.is_dig) begin
                        pins_in  = 8'(tok.nib);
                        state_in = jfmp_pkg::ST_QP_DIGS;
                     end else begin
                        err_in    = 1'b1;
                        erridx_in = idx_ff;
                     end
                  end
               end
               jfmp_pkg::ST_QF_FIRST: begin
                  if (!tok.is_ws) begin
                     if (tok.is_dig) begin
                        fuses_in = 16'(tok.nib);
                        state_in = jfmp_pkg::ST_QF_DIGS;
                     end else begin
                        err_in    = 1'b1;
                        erridx_in = idx_ff;
                     end
                  end
               end
               jfmp_pkg::ST_QP_DIGS: begin
                  if (tok.is_dig) begin
                     pins_in = (pins_mul > 12'd255) ? 8'hFF : pins_mul[7:0];
                  end else if (tok.is_ws) begin
                     state_in = jfmp_pkg::ST_Q_TAIL;
                  end else begin
                     err_in    = 1'b1;
                     erridx_in = idx_ff;
                  end
               end
               jfmp_pkg::ST_QF_DIGS: begin
                  if (tok.is_dig) begin
                     fuses_in = (fuses_mul > 20'd65535) ? 16'hFFFF : fuses_mul[15:0];
                  end else if (tok.is_ws) begin
                     state_in = jfmp_pkg::ST_Q_TAIL;
                  end else begin
                     err_in    = 1'b1;
                     erridx_in = idx_ff;
                  end
               end
               jfmp_pkg::ST_Q_TAIL: begin
                  if (!tok.is_ws) begin
                     err_in    = 1'b1;
                     erridx_in = idx_ff;
                  end
               end
               jfmp_pkg::ST_G_BIT: begin
                  if (!tok.is_ws) begin
                     if (is_bit) begin
                        sec_in   = tok.nib[0];
                        state_in = jfmp_pkg::ST_SKIP;
                     end else begin
                        err_in    = 1'b1;
                        erridx_in = idx_ff;
                     end
                  end
               end
               jfmp_pkg::ST_C_FIRST: begin
                  if (!tok.is_ws) begin
                     if (tok.is_hex) begin
                        csum_in  = 16'(tok.nib);
                        state_in = jfmp_pkg::ST_C_DIGS;
                     end else begin
                        err_in    = 1'b1;
                        erridx_in = idx_ff;
                     end
                  end
               end
               jfmp_pkg::ST_C_DIGS: begin
                  if (tok.is_hex) begin
                     csum_in = {csum_ff[11:0], tok.nib};
                  end else if (tok.is_ws) begin
                     state_in = jfmp_pkg::ST_CMD;
                  end else begin
                     err_in    = 1'b1;
                     erridx_in = idx_ff;
                  end
               end
               default: begin
                  state_in = state_ff;
               end
            endcase
         end
      end

      // Advance the character index, holding at the limit
      idx_in = (idx_ff == IDX_MAX) ? idx_ff : idx_ff + IW'(1);

      // Assemble the result beat from the updated state
      pos_src   = err_in ? erridx_in : idx_ff;
      pos_wide  = 32'(pos_src);
      addr_wide = 32'(fa_src);

      res.write_valid    = wv;
      res.fill_valid     = fv;
      res.bit_value      = bv;
      res.fuse_address   = addr_wide[13:0];
      res.parse_error    = err_in;
      res.error_position = (pos_wide > 32'd65535) ? 16'hFFFF : pos_wide[15:0];
      res.done_res       = tok.last;
      res.pin_count      = pins_in;
      res.fuse_total     = fuses_in;
      res.security_bit   = sec_in;
      res.checksum_given = csum_in;

      // Drop all state after the last character
      if (tok.last) begin
         state_in  = jfmp_pkg::ST_OUTSIDE;
         addr_in   = '0;
         pins_in   = '0;
         fuses_in  = '0;
         sec_in    = 1'b0;
         csum_in   = '0;
         idx_in    = '0;
         err_in    = 1'b0;
         erridx_in = '0;
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= jfmp_pkg::ST_OUTSIDE;
         addr_ff   <= '0;
         pins_ff   <= '0;
         fuses_ff  <= '0;
         sec_ff    <= 1'b0;
         csum_ff   <= '0;
         idx_ff    <= '0;
         err_ff    <= 1'b0;
         erridx_ff <= '0;
      end else if (fire) begin
         state_ff  <= state_in;
         addr_ff   <= addr_in;
         pins_ff   <= pins_in;
         fuses_ff  <= fuses_in;
         sec_ff    <= sec_in;
         csum_ff   <= csum_in;
         idx_ff    <= idx_in;
         err_ff    <= err_in;
         erridx_ff <= erridx_in;
      end
   end

   // Queue result beats toward the consumer
   jfmp_fifo2 #(
      .WIDTH(RES_W)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fire),
      .push_data(RES_W'(res)),
      .full     (oq_full),
      .pop      (rsp_pop),
      .pop_data (rsp_bits),
      .empty    (rsp_empty)
   );

   assign rsp = jfmp_pkg::result_type'(rsp_bits);

endmodule

[design/jedec_fuse_map_parser.sv]
// ----------------------------------------------------------------------------
// JEDEC fuse map parser
// Streams the text of a JEDEC fuse file and reports fuse writes, fills,
// header counts, the security bit, the checksum field and parse errors.
// ----------------------------------------------------------------------------
// One result beat comes out for every character pushed in, in order. The
// block sustains one character per clock while results are popped: the
// back-end field state machine makes one parse step per cycle, and
// two-entry queues sit on each side of it, so a push is taken while earlier
// results still wait. A character's token and then its result are queued.
// The last character of a file (req_last_char high) gets a result with
// done_res set and returns the parser to reset, ready for the next file.
module jedec_fuse_map_parser #(
   parameter int FUSE_CAPACITY   = jfmp_pkg::FUSE_CAPACITY_DEF,
   parameter int MAX_TEXT_LENGTH = jfmp_pkg::MAX_TEXT_LENGTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_character,
   input  logic        req_last_char,
   input  logic        push,
   output logic        full,
   output logic        rsp_write_valid,
   output logic        rsp_fill_valid,
   output logic        rsp_bit_value,
   output logic [13:0] rsp_fuse_address,
   output logic        rsp_parse_error,
   output logic [15:0] rsp_error_position,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_pin_count,
   output logic [15:0] rsp_fuse_total,
   output logic        rsp_security_bit,
   output logic [15:0] rsp_checksum_given,
   output logic        empty,
   input  logic        pop
);

   jfmp_pkg::token_type  tok;
   logic                 tok_empty;
   logic                 tok_pop;
   jfmp_pkg::result_type rsp;

   // Accept and classify characters
   jfmp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_character(req_character),
      .req_last_char(req_last_char),
      .req_push     (push),
      .req_full     (full),
      .tok_pop      (tok_pop),
      .tok          (tok),
      .tok_empty    (tok_empty)
   );

   // Parse and report
   jfmp_back #(
      .FUSE_CAPACITY  (FUSE_CAPACITY),
      .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .tok      (tok),
      .tok_empty(tok_empty),
      .tok_pop  (tok_pop),
      .rsp      (rsp),
      .rsp_empty(empty),
      .rsp_pop  (pop)
   );

   // Break out the result beat
   assign rsp_write_valid    = rsp.write_valid;
   assign rsp_fill_valid     = rsp.fill_valid;
   assign rsp_bit_value      = rsp.bit_value;
   assign rsp_fuse_address   = rsp.fuse_address;
   assign rsp_parse_error    = rsp.parse_error;
   assign rsp_error_position = rsp.error_position;
   assign rsp_done_res       = rsp.done_res;
   assign rsp_pin_count      = rsp.pin_count;
   assign rsp_fuse_total     = rsp.fuse_total;
   assign rsp_security_bit   = rsp.security_bit;
   assign rsp_checksum_given = rsp.checksum_given;

endmodule

[design/jfmp_checker.sv]
// ----------------------------------------------------------------------------
// JEDEC fuse map parser port checker
// Watches the top-level ports for reset behavior, stall holding, error
// stickiness and exclusive write/fill beats.
// ----------------------------------------------------------------------------
`include "jedec_fuse_map_parser_macros.svh"

module jfmp_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        rsp_write_valid,
   input logic        rsp_fill_valid,
   input logic [13:0] rsp_fuse_address,
   input logic        rsp_parse_error,
   input logic [15:0] rsp_error_position,
   input logic        rsp_done_res,
   input logic [15:0] rsp_checksum_given,
   input logic        empty,
   input logic        pop
);

   // Both queues drain on reset
   `JFMP_ASSERT_AFTER_RESET(a_reset_drains, empty && !full, "queues not drained by reset")

   // A stalled result holds
   `JFMP_ASSERT_NEXT(a_stall_holds, !empty && !pop, !empty && $stable(rsp_fuse_address) && $stable(rsp_error_position) && $stable(rsp_checksum_given) && $stable(rsp_write_valid), "stalled result changed")

   // An error stays raised until the end of the file
   `JFMP_ASSERT_NEXT(a_error_sticky, pop && !empty && rsp_parse_error && !rsp_done_res, empty || rsp_parse_error, "error flag dropped within a file")

   // The recorded error position does not move
   `JFMP_ASSERT_NEXT(a_error_pos_held, pop && !empty && rsp_parse_error && !rsp_done_res, empty || rsp_error_position == $past(rsp_error_position), "error position moved")

   // A beat never carries both a write and a fill
   `JFMP_ASSERT_NOW(a_write_fill_excl, empty || !(rsp_write_valid && rsp_fill_valid), "write and fill on one beat")

endmodule

bind jedec_fuse_map_parser jfmp_port_checker u_checker (.*);

[sim/jfmp_checker.sv]
// ----------------------------------------------------------------------------
// JEDEC fuse map parser checker
// Watches the character and result channels, runs its own field parser on
// every accepted character, and compares each popped result beat, field by
// field, against the oldest predicted beat. Reports a failure count and the
// number of beats still awaited.
// ----------------------------------------------------------------------------
module jfmp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_character,
   input  logic        req_last_char,
   input  logic        push,
   input  logic        full,
   input  logic        rsp_write_valid,
   input  logic        rsp_fill_valid,
   input  logic        rsp_bit_value,
   input  logic [13:0] rsp_fuse_address,
   input  logic        rsp_parse_error,
   input  logic [15:0] rsp_error_position,
   input  logic        rsp_done_res,
   input  logic [7:0]  rsp_pin_count,
   input  logic [15:0] rsp_fuse_total,
   input  logic        rsp_security_bit,
   input  logic [15:0] rsp_checksum_given,
   input  logic        empty,
   input  logic        pop,
   output int          fail_count,
   output int          beats_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CAPACITY   = jfmp_pkg::FUSE_CAPACITY_DEF;
   localparam int unsigned TEXT_LIMIT = jfmp_pkg::MAX_TEXT_LENGTH_DEF;

   // Characters that steer the field machine
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_L     = 8'h4C;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_Q     = 8'h51;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Parser state mirrored from the block
   jfmp_pkg::parse_state_type field_state;
   int unsigned               addr_acc;
   int unsigned               pins_acc;
   int unsigned               fuses_acc;
   int unsigned               csum_acc;
   int unsigned               text_idx;
   int unsigned               err_idx;
   logic                      sec_bit;
   logic                      err_seen;

   jfmp_pkg::result_type parsed_beats[$];
   int                   beat_no = 0;

   initial fail_count = 0;
   initial beats_pending = 0;

   function automatic logic is_space(logic [7:0] ch);
      return ch == CH_SPACE || (ch >= 8'h09 && ch <= 8'h0D);
   endfunction

   function automatic logic is_digit(logic [7:0] ch);
      return ch >= CH_ZERO && ch <= 8'h39;
   endfunction

   // Nibble value of a hex digit, 16 when the character is none
   function automatic int unsigned hex_value(logic [7:0] ch);
      if (is_digit(ch)) return ch - CH_ZERO;
      if (ch >= 8'h61 && ch <= 8'h66) return ch - 8'h57;
      if (ch >= 8'h41 && ch <= 8'h46) return ch - 8'h37;
      return 16;
   endfunction

   function automatic int unsigned sat16(int unsigned v);
      return (v > 65535) ? 65535 : v;
   endfunction

   task automatic clear_parser();
      field_state = jfmp_pkg::ST_OUTSIDE;
      addr_acc    = 0;
      pins_acc    = 0;
      fuses_acc   = 0;
      csum_acc    = 0;
      text_idx    = 0;
      err_idx     = 0;
      sec_bit     = 1'b0;
      err_seen    = 1'b0;
   endtask

   // Latch only the first error position
   task automatic note_error(int unsigned at);
      if (!err_seen) begin
         err_seen = 1'b1;
         err_idx  = at;
      end
   endtask

   // Advance the field machine by one character and form its result beat
   task automatic parse_char(input logic [7:0] ch, input logic lst,
                             output jfmp_pkg::result_type r);
      int unsigned at;
      int unsigned nxt;
      int unsigned h;
      int unsigned pos;
      logic        wv;
      logic        fv;
      logic        bv;
      logic [13:0] fa;
      at = text_idx;
      wv = 1'b0;
      fv = 1'b0;
      bv = 1'b0;
      fa = '0;
      if (at >= TEXT_LIMIT) note_error(at);
      if (!err_seen) begin
         if (ch == CH_STAR) begin
            field_state = jfmp_pkg::ST_CMD;
         end else begin
            case (field_state)
               jfmp_pkg::ST_CMD: begin
                  if (!is_space(ch)) begin
                     if (ch == CH_L) begin
                        addr_acc    = 0;
                        field_state = jfmp_pkg::ST_L_FIRST;
                     end else if (ch == CH_F) field_state = jfmp_pkg::ST_F_BIT;
                     else if (ch == CH_G) field_state = jfmp_pkg::ST_G_BIT;
                     else if (ch == CH_Q) field_state = jfmp_pkg::ST_Q_SEL;
                     else if (ch == CH_C) field_state = jfmp_pkg::ST_C_FIRST;
                     else field_state = jfmp_pkg::ST_SKIP;
                  end
               end
               jfmp_pkg::ST_L_FIRST: begin
                  if (is_digit(ch)) begin
                     addr_acc    = ch - CH_ZERO;
                     field_state = jfmp_pkg::ST_L_ADDR;
                  end else note_error(at);
               end
               jfmp_pkg::ST_L_ADDR: begin
                  if (is_space(ch)) field_state = jfmp_pkg::ST_L_BITS;
                  else if (is_digit(ch)) begin
                     // saturate at capacity so that later bits fail
                     nxt      = addr_acc * 10 + (ch - CH_ZERO);
                     addr_acc = (nxt >= CAPACITY) ? CAPACITY : nxt;
                  end else note_error(at);
               end
               jfmp_pkg::ST_F_BIT: begin
                  if (!is_space(ch)) begin
                     if (ch == CH_ZERO || ch == CH_ONE) begin
                        fv          = 1'b1;
                        bv          = ch[0];
                        field_state = jfmp_pkg::ST_SKIP;
                     end else note_error(at);
                  end
               end
               jfmp_pkg::ST_L_BITS: begin
                  if (!is_space(ch)) begin
                     if ((ch == CH_ZERO || ch == CH_ONE) && addr_acc < CAPACITY) begin
                        wv       = 1'b1;
                        bv       = ch[0];
                        fa       = addr_acc[13:0];
                        addr_acc = addr_acc + 1;
                     end else note_error(at);
                  end
               end
               jfmp_pkg::ST_Q_SEL: begin
                  if (!is_space(ch)) begin
                     if (ch == CH_P) begin
                        pins_acc    = 0;
                        field_state = jfmp_pkg::ST_QP_FIRST;
                     end else if (ch == CH_F) begin
                        fuses_acc   = 0;
                        field_state = jfmp_pkg::ST_QF_FIRST;
                     end else field_state = jfmp_pkg::ST_CMD;
                  end
               end
               jfmp_pkg::ST_QP_FIRST, jfmp_pkg::ST_QF_FIRST: begin
                  if (!is_space(ch)) begin
                     if (!is_digit(ch)) note_error(at);
                     else if (field_state == jfmp_pkg::ST_QP_FIRST) begin
                        pins_acc    = ch - CH_ZERO;
                        field_state = jfmp_pkg::ST_QP_DIGS;
                     end else begin
                        fuses_acc   = ch - CH_ZERO;
                        field_state = jfmp_pkg::ST_QF_DIGS;
                     end
                  end
               end
               jfmp_pkg::ST_QP_DIGS: begin
                  if (is_digit(ch)) begin
                     nxt      = pins_acc * 10 + (ch - CH_ZERO);
                     pins_acc = (nxt > 255) ? 255 : nxt;
                  end else if (is_space(ch)) field_state = jfmp_pkg::ST_Q_TAIL;
                  else note_error(at);
               end
               jfmp_pkg::ST_QF_DIGS: begin
                  if (is_digit(ch)) fuses_acc = sat16(fuses_acc * 10 + (ch - CH_ZERO));
                  else if (is_space(ch)) field_state = jfmp_pkg::ST_Q_TAIL;
                  else note_error(at);
               end
               jfmp_pkg::ST_Q_TAIL: begin
                  if (!is_space(ch)) note_error(at);
               end
               jfmp_pkg::ST_G_BIT: begin
                  if (!is_space(ch)) begin
                     if (ch == CH_ZERO || ch == CH_ONE) begin
                        sec_bit     = ch[0];
                        field_state = jfmp_pkg::ST_SKIP;
                     end else note_error(at);
                  end
               end
               jfmp_pkg::ST_C_FIRST: begin
                  if (!is_space(ch)) begin
                     h = hex_value(ch);
                     if (h < 16) begin
                        csum_acc    = h;
                        field_state = jfmp_pkg::ST_C_DIGS;
                     end else note_error(at);
                  end
               end
               jfmp_pkg::ST_C_DIGS: begin
                  // checksum wraps at 16 bits
                  h = hex_value(ch);
                  if (h < 16) csum_acc = ((csum_acc << 4) + h) & 32'h0000_FFFF;
                  else if (is_space(ch)) field_state = jfmp_pkg::ST_CMD;
                  else note_error(at);
               end
               default: begin
               end
            endcase
         end
      end

      if (text_idx < TEXT_LIMIT) text_idx = text_idx + 1;

      pos              = sat16(err_seen ? err_idx : at);
      r.write_valid    = wv;
      r.fill_valid     = fv;
      r.bit_value      = bv;
      r.fuse_address   = fa;
      r.parse_error    = err_seen;
      r.error_position = pos[15:0];
      r.done_res       = lst;
      r.pin_count      = pins_acc[7:0];
      r.fuse_total     = fuses_acc[15:0];
      r.security_bit   = sec_bit;
      r.checksum_given = csum_acc[15:0];

      // end of file: start over
      if (lst) clear_parser();
   endtask

   // Compare one popped beat with its prediction
   task automatic compare_beat(input jfmp_pkg::result_type want,
                               input jfmp_pkg::result_type got);
      string diffs;
      diffs = "";
      if (got.write_valid !== want.write_valid)
         diffs = {diffs, $sformatf(" write_valid %0h/%0h", want.write_valid, got.write_valid)};
      if (got.fill_valid !== want.fill_valid)
         diffs = {diffs, $sformatf(" fill_valid %0h/%0h", want.fill_valid, got.fill_valid)};
      if (got.bit_value !== want.bit_value)
         diffs = {diffs, $sformatf(" bit_value %0h/%0h", want.bit_value, got.bit_value)};
      if (got.fuse_address !== want.fuse_address)
         diffs = {diffs, $sformatf(" fuse_address %0d/%0d", want.fuse_address,
                                   got.fuse_address)};
      if (got.parse_error !== want.parse_error)
         diffs = {diffs, $sformatf(" parse_error %0h/%0h", want.parse_error, got.parse_error)};
      if (got.error_position !== want.error_position)
         diffs = {diffs, $sformatf(" error_position %0d/%0d", want.error_position,
                                   got.error_position)};
      if (got.done_res !== want.done_res)
         diffs = {diffs, $sformatf(" done_res %0h/%0h", want.done_res, got.done_res)};
      if (got.pin_count !== want.pin_count)
         diffs = {diffs, $sformatf(" pin_count %0d/%0d", want.pin_count, got.pin_count)};
      if (got.fuse_total !== want.fuse_total)
         diffs = {diffs, $sformatf(" fuse_total %0d/%0d", want.fuse_total, got.fuse_total)};
      if (got.security_bit !== want.security_bit)
         diffs = {diffs, $sformatf(" security_bit %0h/%0h", want.security_bit,
                                   got.security_bit)};
      if (got.checksum_given !== want.checksum_given)
         diffs = {diffs, $sformatf(" checksum_given %0h/%0h", want.checksum_given,
                                   got.checksum_given)};
      if (diffs != "") begin
         fail_count++;
         if (fail_count <= 10)
            $display("%t: beat %0d mismatch (expected/actual):%s", $realtime, beat_no, diffs);
      end
   endtask

   // Check popped beats first, then predict the pushed character
   always @(posedge clock) begin
      jfmp_pkg::result_type got;
      jfmp_pkg::result_type want;
      jfmp_pkg::result_type fresh;
      if (reset) begin
         clear_parser();
         parsed_beats.delete();
      end else begin
         if (pop && !empty) begin
            got.write_valid    = rsp_write_valid;
            got.fill_valid     = rsp_fill_valid;
            got.bit_value      = rsp_bit_value;
            got.fuse_address   = rsp_fuse_address;
            got.parse_error    = rsp_parse_error;
            got.error_position = rsp_error_position;
            got.done_res       = rsp_done_res;
            got.pin_count      = rsp_pin_count;
            got.fuse_total     = rsp_fuse_total;
            got.security_bit   = rsp_security_bit;
            got.checksum_given = rsp_checksum_given;
            if (parsed_beats.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%t: beat %0d popped with nothing expected", $realtime, beat_no);
            end else begin
               want = parsed_beats.pop_front();
               compare_beat(want, got);
            end
            beat_no++;
         end
         if (push && !full) begin
            parse_char(req_character, req_last_char, fresh);
            parsed_beats.push_back(fresh);
         end
      end
      beats_pending <= parsed_beats.size();
   end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// JEDEC fuse map parser testbench
// Feeds fuse file text one character per beat: a few hand-written files
// covering every field kind, saturation and error paths, then random
// well-formed files with noise bytes and early ends. Both sides idle at
// random; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 20_000;
   localparam int RANDOM_ITEMS = 1000;

   localparam logic [7:0] CH_STX   = 8'h02;
   localparam logic [7:0] CH_ETX   = 8'h03;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic [7:0]  req_character = '0;
   logic        req_last_char = 1'b0;
   logic        push          = 1'b0;
   logic        pop           = 1'b0;
   logic        full;
   logic        empty;
   logic        rsp_write_valid;
   logic        rsp_fill_valid;
   logic        rsp_bit_value;
   logic [13:0] rsp_fuse_address;
   logic        rsp_parse_error;
   logic [15:0] rsp_error_position;
   logic        rsp_done_res;
   logic [7:0]  rsp_pin_count;
   logic [15:0] rsp_fuse_total;
   logic        rsp_security_bit;
   logic [15:0] rsp_checksum_given;

   int   fail_count;
   int   beats_pending;
   int   cycles     = 0;
   int   chars_sent = 0;
   logic quiet      = 1'b0;

   logic [7:0] text_buf[$];

   jedec_fuse_map_parser u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_character      (req_character),
      .req_last_char      (req_last_char),
      .push               (push),
      .full               (full),
      .rsp_write_valid    (rsp_write_valid),
      .rsp_fill_valid     (rsp_fill_valid),
      .rsp_bit_value      (rsp_bit_value),
      .rsp_fuse_address   (rsp_fuse_address),
      .rsp_parse_error    (rsp_parse_error),
      .rsp_error_position (rsp_error_position),
      .rsp_done_res       (rsp_done_res),
      .rsp_pin_count      (rsp_pin_count),
      .rsp_fuse_total     (rsp_fuse_total),
      .rsp_security_bit   (rsp_security_bit),
      .rsp_checksum_given (rsp_checksum_given),
      .empty              (empty),
      .pop                (pop)
   );

   jfmp_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_character      (req_character),
      .req_last_char      (req_last_char),
      .push               (push),
      .full               (full),
      .rsp_write_valid    (rsp_write_valid),
      .rsp_fill_valid     (rsp_fill_valid),
      .rsp_bit_value      (rsp_bit_value),
      .rsp_fuse_address   (rsp_fuse_address),
      .rsp_parse_error    (rsp_parse_error),
      .rsp_error_position (rsp_error_position),
      .rsp_done_res       (rsp_done_res),
      .rsp_pin_count      (rsp_pin_count),
      .rsp_fuse_total     (rsp_fuse_total),
      .rsp_security_bit   (rsp_security_bit),
      .rsp_checksum_given (rsp_checksum_given),
      .empty              (empty),
      .pop                (pop),
      .fail_count         (fail_count),
      .beats_pending      (beats_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the result side now and then
   always @(posedge clock) begin
      pop <= quiet || ($urandom_range(0, 99) >= 9);
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("** jedec_fuse_map_parser: FAILED **");
         $finish;
      end
   end

   // Offer one character, idling first at random, and hold until taken
   task automatic send_char(input logic [7:0] ch, input logic lst);
      while (!quiet && $urandom_range(0, 99) < 9) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push          <= 1'b1;
      req_character <= ch;
      req_last_char <= lst;
      do @(posedge clock); while (full);
      chars_sent++;
   endtask

   // Drop push and hold off until every result beat has been popped
   task automatic drain();
      push <= 1'b0;
      do @(posedge clock); while (beats_pending != 0);
   endtask

   task automatic add_str(input string s);
      foreach (s[i]) text_buf.push_back(s[i]);
   endtask

   task automatic add_space();
      int unsigned pick;
      pick = $urandom_range(0, 6);
      text_buf.push_back((pick >= 5) ? CH_SPACE : 8'(8'h09 + pick));
   endtask

   task automatic add_bit();
      add_str($urandom_range(0, 1) ? "1" : "0");
   endtask

   // Send the buffered file, marking its final character as last
   task automatic send_file();
      foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
      text_buf.delete();
   endtask

   // Decimal value: short half the time, else large, sometimes enough to saturate
   function automatic int unsigned pick_count();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 9);
         1:       return $urandom_range(10, 300);
         2:       return $urandom_range(300, 70000);
         default: return $urandom_range(70000, 9999999);
      endcase
   endfunction

   // Append one random field body after its star
   task automatic add_field();
      int unsigned addr;
      int unsigned v;
      int          n;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            add_str("L");
            case ($urandom_range(0, 9))
               0, 1:    addr = $urandom_range(16370, 16383);
               2:       addr = $urandom_range(16384, 99999);
               default: addr = $urandom_range(0, 60);
            endcase
            add_str($sformatf("%0d", addr));
            add_space();
            n = $urandom_range(1, 12);
            repeat (n) begin
               add_bit();
               if ($urandom_range(0, 4) == 0) add_space();
            end
         end
         3: begin
            add_str("F");
            if ($urandom_range(0, 1)) add_space();
            add_bit();
         end
         4: begin
            add_str("G");
            add_bit();
         end
         5, 6: begin
            add_str("Q");
            if ($urandom_range(0, 3) == 0) add_space();
            add_str($urandom_range(0, 1) ? "P" : "F");
            add_str($sformatf("%0d", pick_count()));
            add_space();
         end
         7: begin
            add_str("C");
            n = $urandom_range(1, 6);
            repeat (n) begin
               v = $urandom_range(0, 15);
               if (v < 10) text_buf.push_back(8'(8'h30 + v));
               else text_buf.push_back(8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10));
            end
            add_space();
         end
         8: begin
            // Q followed by a random capital letter
            add_str("Q");
            text_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
         end
         default: begin
            add_str("N note ");
            add_str($sformatf("%0d", $urandom_range(0, 999)));
         end
      endcase
      // occasional stray byte, any value
      if ($urandom_range(0, 11) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   // Random file: preamble, a few fields, closing star; sometimes cut short
   task automatic build_random_file();
      int n;
      int keep;
      text_buf.push_back(CH_STX);
      n = $urandom_range(0, 2);
      repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
      n = $urandom_range(1, 6);
      repeat (n) begin
         text_buf.push_back(CH_STAR);
         add_field();
      end
      text_buf.push_back(CH_STAR);
      text_buf.push_back(CH_ETX);
      if ($urandom_range(0, 9) == 0) begin
         keep = $urandom_range(1, text_buf.size());
         text_buf = text_buf[0:keep-1];
      end
   endtask

   initial begin
      int start_count;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every field kind, count limits, lowercase hex, Q with neither P nor F
      text_buf.push_back(CH_STX);
      add_str("*F1*G1*QP255\t*QF65535 *Q?*Cbeef *L0 01*");
      text_buf.push_back(CH_ETX);
      send_file();
      drain();

      // Saturating counts, wrapping checksum, writes running past capacity
      add_str("*QP9999 *QF999999 *C1A2b3F *L16382 1 0 1");
      send_file();

      // Oversized address, then frozen state after the error
      add_str("*L99999 1*G1");
      send_file();

      // NUL byte as an ordinary character, then a malformed L field
      add_str("*");
      text_buf.push_back(CH_NUL);
      add_str("*Lx1*F2");
      send_file();
      drain();

      // Random files, with a stretch of no idling and a stretch with full drains
      start_count = chars_sent;
      while (chars_sent - start_count < RANDOM_ITEMS) begin
         quiet = (chars_sent - start_count >= 400) && (chars_sent - start_count < 600);
         build_random_file();
         send_file();
         if (chars_sent - start_count >= 700 && chars_sent - start_count < 760) drain();
      end
      quiet = 1'b0;

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("** jedec_fuse_map_parser: PASSED **");
      end else begin
         $display("** jedec_fuse_map_parser: FAILED **");
      end
      $finish;
   end

endmodule
